FILE: src/mm3_pkg.sv
// Shared types and constants for the streaming MurmurHash3 (x86, 32-bit) block.
`default_nettype none

package mm3_pkg;

    // Mixing and finalization constants of MurmurHash3 x86_32.
    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    // Depth of the request queue between the front and the back.
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Kinds of request that the front hands to the back.
    typedef enum logic [1:0] {
        CMD_MIX       = 2'd0,
        CMD_FINAL     = 2'd1,
        CMD_MIX_FINAL = 2'd2
    } cmd_op_t;

    // One request: a block or tail word, the byte count and the seed of its key.
    typedef struct packed {
        cmd_op_t     op;
        logic        tail;
        logic [31:0] k;
        logic [31:0] count;
        logic [31:0] seed;
    } cmd_t;

    // Queue status seen by the front.
    typedef struct packed {
        logic full;
        logic empty;
    } cmd_status_t;

    // Sequencer states of the back.
    typedef enum logic [2:0] {
        BK_IDLE    = 3'd0,
        BK_K1      = 3'd1,
        BK_K2      = 3'd2,
        BK_COMBINE = 3'd3,
        BK_AV1     = 3'd4,
        BK_AV2     = 3'd5,
        BK_AV3     = 3'd6
    } back_state_t;

endpackage

`default_nettype wire

FILE: src/mm3_front.sv
// Front: accepts key bytes, gathers 32-bit blocks and issues mix and finish requests.
`default_nettype none

module mm3_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [31:0]         cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,
    input  wire logic                s_tuser,
    input  wire logic                s_tlast,
    input  wire mm3_pkg::cmd_status_t q_status,
    output logic                     q_push,
    output mm3_pkg::cmd_t            q_data
);
    import mm3_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] key_seed_reg, key_seed_next;
    logic        in_key_reg, in_key_next;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] count_reg, count_next;
    logic        accept;
    logic        active;
    logic [31:0] seed_now;

    // The seed register takes every write at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_valid) begin
            seed_reg <= cfg_data;
        end
    end

    // A byte is taken whenever the queue has room for the request it may cause.
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign active   = accept && (s_tuser || s_tlast);
    assign seed_now = in_key_reg ? key_seed_reg : seed_reg;

    // Block gathering and request generation.
    always_comb begin
        in_key_next   = in_key_reg;
        key_seed_next = key_seed_reg;
        partial_next  = partial_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        q_push        = 1'b0;
        q_data.op     = CMD_MIX;
        q_data.tail   = 1'b0;
        q_data.k      = {s_tdata, partial_reg};
        q_data.count  = count_reg;
        q_data.seed   = seed_now;

        if (active) begin
            in_key_next   = 1'b1;
            key_seed_next = seed_now;
            if (s_tuser) begin
                count_next = count_reg + 32'd1;
                case (pos_reg)
                    2'd0: partial_next[7:0]   = s_tdata;
                    2'd1: partial_next[15:8]  = s_tdata;
                    2'd2: partial_next[23:16] = s_tdata;
                    default: partial_next     = '0;
                endcase
                pos_next = pos_reg + 2'd1;
                // A completed block goes out as a mix request.
                if (pos_reg == 2'd3) begin
                    q_push = 1'b1;
                end
            end
            q_data.count = count_next;
            if (s_tlast) begin
                q_push = 1'b1;
                if (s_tuser && pos_reg == 2'd3) begin
                    q_data.op = CMD_MIX_FINAL;
                end else begin
                    q_data.op   = CMD_FINAL;
                    q_data.tail = (pos_next != 2'd0);
                    q_data.k    = {8'h00, partial_next};
                end
                // Closing the key returns the gathering state to its reset values.
                in_key_next  = 1'b0;
                partial_next = '0;
                pos_next     = '0;
                count_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_key_reg   <= 1'b0;
            key_seed_reg <= '0;
            partial_reg  <= '0;
            pos_reg      <= '0;
            count_reg    <= '0;
        end else begin
            in_key_reg   <= in_key_next;
            key_seed_reg <= key_seed_next;
            partial_reg  <= partial_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/mm3_cmd_fifo.sv
// Short request queue between the front and the back.
`default_nettype none

module mm3_cmd_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire mm3_pkg::cmd_t        push_data,
    input  wire logic                 pop,
    output mm3_pkg::cmd_t             pop_data,
    output mm3_pkg::cmd_status_t      status
);
    import mm3_pkg::*;

    cmd_t                 mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] fill_reg;
    logic                 do_push;
    logic                 do_pop;

    assign status.full  = (fill_reg == CMD_CNT_W'(CMD_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    // Storage is written only; entries are read once they are counted.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointer and fill bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CMD_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CMD_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/mm3_back.sv
// Back: runs block mixes and the final avalanche on a shared multiplier sequence.
`default_nettype none

module mm3_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mm3_pkg::cmd_status_t q_status,
    input  wire mm3_pkg::cmd_t        q_data,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata
);
    import mm3_pkg::*;

    back_state_t state_reg, state_next;
    cmd_op_t     op_reg, op_next;
    logic        tail_reg, tail_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] count_reg, count_next;
    logic        in_key_reg, in_key_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [31:0] k_rot;
    logic [31:0] h_xk;
    logic [31:0] h_rot;
    logic [31:0] h_cnt;
    logic        out_free;

    assign k_rot    = {k_reg[16:0], k_reg[31:17]};
    assign h_xk     = h_reg ^ k_reg;
    assign h_rot    = {h_xk[18:0], h_xk[31:19]};
    assign h_cnt    = h_reg ^ count_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Sequencer: at most one multiply per step, registered between steps.
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        tail_next      = tail_reg;
        k_next         = k_reg;
        h_next         = h_reg;
        count_next     = count_reg;
        in_key_next    = in_key_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    op_next    = q_data.op;
                    tail_next  = q_data.tail;
                    k_next     = q_data.k;
                    count_next = q_data.count;
                    h_next     = in_key_reg ? h_reg : q_data.seed;
                    if (q_data.op == CMD_FINAL && !q_data.tail) begin
                        state_next = BK_AV1;
                    end else begin
                        state_next = BK_K1;
                    end
                end
            end
            BK_K1: begin
                k_next     = k_reg * MIX_C1;
                state_next = BK_K2;
            end
            BK_K2: begin
                k_next     = k_rot * MIX_C2;
                state_next = BK_COMBINE;
            end
            BK_COMBINE: begin
                if (op_reg == CMD_FINAL) begin
                    // Tail word is folded in without the block round.
                    h_next     = h_xk;
                    state_next = BK_AV1;
                end else begin
                    h_next = (h_rot << 2) + h_rot + MIX_ADD;
                    if (op_reg == CMD_MIX) begin
                        in_key_next = 1'b1;
                        state_next  = BK_IDLE;
                    end else begin
                        state_next = BK_AV1;
                    end
                end
            end
            BK_AV1: begin
                h_next     = (h_cnt ^ (h_cnt >> 16)) * FIN_M1;
                state_next = BK_AV2;
            end
            BK_AV2: begin
                h_next     = (h_reg ^ (h_reg >> 13)) * FIN_M2;
                state_next = BK_AV3;
            end
            BK_AV3: begin
                // Wait here until the output register can take the hash.
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = h_reg ^ (h_reg >> 16);
                    in_key_next    = 1'b0;
                    state_next     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            in_key_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_key_reg    <= in_key_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        tail_reg     <= tail_next;
        k_reg        <= k_next;
        h_reg        <= h_next;
        count_reg    <= count_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: src/murmur3_stream_hash.sv
// Top level of the streaming MurmurHash3 x86_32 hasher.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid / s_tready  s_tdata = key byte, s_tuser = byte valid,
//                                             s_tlast = last item of the key
//   m_        out        m_tvalid / m_tready  m_tdata = 32-bit hash
//   cfg_      in         cfg_valid/cfg_ready  cfg_data = seed
//
// Bytes are taken one per cycle while the two-entry request queue has room.
// Each full block takes the back through dequeue, two multiply steps and combine,
// so a steady stream of valid bytes runs at one byte per cycle.
// Closing a key runs any pending mix, two avalanche multiplies, then the output step.
// Reset is synchronous and active low; no memory needs clearing after it.
// A stalled m_ side holds the hash in the output register and backs up into the queue.
`default_nettype none

module murmur3_stream_hash (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,   // [31:0] seed
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
    input  wire logic        s_tuser,    // [0] byte_valid
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata     // [31:0] hash
);
    import mm3_pkg::*;

    cmd_t        push_data;
    cmd_t        pop_data;
    cmd_status_t q_status;
    logic        q_push;
    logic        q_pop;

    // Byte gathering and request issue.
    mm3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    // Request queue.
    mm3_cmd_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Mixing and finalization.
    mm3_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // The front never issues a request into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_status.full |-> !q_push)
        else $error("request issued while the queue is full");

    // The back only dequeues when a request is waiting.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_status.empty)
        else $error("request dequeued from an empty queue");

    // A full queue always stalls the byte input.
    assert property (@(posedge aclk) disable iff (!aresetn) q_status.full |-> !s_tready)
        else $error("byte input ready while the queue is full");

    // A push and an empty flag can not both persist: a pushed request is counted.
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (q_push && !q_pop) |=> !q_status.empty)
        else $error("pushed request lost from the queue");

endmodule

`default_nettype wire
